>>> sv/score_digit_display_blink_assert.svh
// Assertion macros for the score digit display blink block.
// Used by sdd_entry and score_digit_display_blink; needs nothing else.
`ifndef SCORE_DIGIT_DISPLAY_BLINK_ASSERT_SVH
`define SCORE_DIGIT_DISPLAY_BLINK_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SDD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SDD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sdd_pkg.sv
// Shared types, constants and functions of the score digit display blink block.
// No dependencies; used by every module of the block.
package sdd_pkg;

   // Configured digit count and blink period
   localparam int DIGIT_COUNT  = 8;
   localparam int BLINK_FRAMES = 16;

   // Output format: eight digit codes, most significant first
   localparam int OUT_DIGITS = 8;
   localparam int BCD_W      = 4 * OUT_DIGITS;
   localparam logic [3:0] BLANK_CODE = 4'd10;

   localparam int EFF_DIGITS = (DIGIT_COUNT > OUT_DIGITS) ? OUT_DIGITS :
                               ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   localparam longint unsigned SCORE_CAP = pow10(EFF_DIGITS) - 1;
   localparam int VALUE_W    = $clog2(SCORE_CAP + 1);
   localparam int CELL_COUNT = VALUE_W;
   localparam int BLINK_W    = $clog2(BLINK_FRAMES);

   typedef logic [OUT_DIGITS-1:0][3:0] digits_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic               blink_enable;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_0;
      logic [3:0] digit_1;
      logic [3:0] digit_2;
      logic [3:0] digit_3;
      logic [3:0] digit_4;
      logic [3:0] digit_5;
      logic [3:0] digit_6;
      logic [3:0] digit_7;
      logic       redrawn;
      logic       visible;
   } rsp_type;

   // Contents of one conversion cell
   typedef struct packed {
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
      logic               redraw;
      logic               visible;
      logic               blank;
   } cell_type;

   // One shift-and-add-3 step: adjust every BCD digit, shift in the next binary bit
   function automatic cell_type dabble_step(input cell_type c);
      cell_type         r;
      logic [BCD_W-1:0] adj;
      logic [3:0]       d;
      r   = c;
      adj = c.bcd;
      for (int j = 0; j < OUT_DIGITS; j++) begin
         d = c.bcd[j*4 +: 4];
         if (d >= 4'd5) begin
            adj[j*4 +: 4] = d + 4'd3;
         end
      end
      r.bcd = {adj[BCD_W-2:0], c.bin[VALUE_W-1]};
      r.bin = {c.bin[VALUE_W-2:0], 1'b0};
      return r;
   endfunction

   // Split BCD into digit codes, blanking leading zeros but never the units digit
   function automatic digits_type blank_digits(input logic [BCD_W-1:0] bcd,
                                               input logic blank);
      digits_type r;
      logic       started;
      logic [3:0] d;
      started = 1'b0;
      for (int j = 0; j < OUT_DIGITS; j++) begin
         d = bcd[(OUT_DIGITS-1-j)*4 +: 4];
         if (!blank || started || d != 4'd0 || j == OUT_DIGITS - 1) begin
            started = 1'b1;
            r[j]    = d;
         end else begin
            r[j] = BLANK_CODE;
         end
      end
      return r;
   endfunction

endpackage

>>> sv/sdd_dabble_cell.sv
// One cell of the binary to BCD conversion chain: a register stage doing one
// shift-and-add-3 step. Depends on sdd_pkg.
module sdd_dabble_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              prev_valid,
   input  sdd_pkg::cell_type prev_data,
   output logic              cur_valid,
   output sdd_pkg::cell_type cur_data
);

   logic              valid_ff;
   sdd_pkg::cell_type data_ff;
   sdd_pkg::cell_type data_in;

   // Apply one conversion step to the item arriving from the neighbor
   assign data_in = sdd_pkg::dabble_step(prev_data);

   // Take the neighbor's slot (item or bubble) whenever this slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && prev_valid) begin
         data_ff <= data_in;
      end
   end

   assign cur_valid = valid_ff;
   assign cur_data  = data_ff;

endmodule

>>> sv/sdd_entry.sv
// Entry stage: clamps the score, decides on a redraw and runs the blink counter.
// Depends on sdd_pkg and score_digit_display_blink_assert.svh.
`include "score_digit_display_blink_assert.svh"

module sdd_entry (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  sdd_pkg::req_type  req,
   input  logic              blank,
   output sdd_pkg::cell_type first_data
);

   logic [sdd_pkg::VALUE_W-1:0] shown_value_ff;
   logic                        shown_valid_ff;
   logic [sdd_pkg::BLINK_W-1:0] blink_count_ff;
   logic                        hidden_ff;

   logic [sdd_pkg::VALUE_W-1:0] value;
   logic                        redraw;
   logic [sdd_pkg::BLINK_W-1:0] blink_count_in;
   logic                        hidden_in;

   // Clamp, compare with the shown value, advance the blink counter
   always_comb begin
      if (req.score[31]) begin
         value = '0;
      end else if (req.score[30:0] > 31'(sdd_pkg::SCORE_CAP)) begin
         value = sdd_pkg::VALUE_W'(sdd_pkg::SCORE_CAP);
      end else begin
         value = req.score[sdd_pkg::VALUE_W-1:0];
      end
      redraw = !shown_valid_ff || (value != shown_value_ff);

      blink_count_in = blink_count_ff;
      hidden_in      = hidden_ff;
      if (req.blink_enable) begin
         if (blink_count_ff == sdd_pkg::BLINK_W'(sdd_pkg::BLINK_FRAMES - 1)) begin
            blink_count_in = '0;
            hidden_in      = !hidden_ff;
         end else begin
            blink_count_in = blink_count_ff + 1'b1;
         end
      end

      first_data.bin     = value;
      first_data.bcd     = '0;
      first_data.redraw  = redraw;
      first_data.visible = !hidden_in;
      first_data.blank   = blank;
   end

   // Update frame state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         shown_value_ff <= '0;
         shown_valid_ff <= 1'b0;
         blink_count_ff <= '0;
         hidden_ff      <= 1'b0;
      end else if (accept) begin
         blink_count_ff <= blink_count_in;
         hidden_ff      <= hidden_in;
         if (redraw) begin
            shown_value_ff <= value;
            shown_valid_ff <= 1'b1;
         end
      end
   end

   `SDD_ASSERT_NXT(a_blink_hold, clock, reset, accept && !req.blink_enable, $stable(hidden_ff) && $stable(blink_count_ff), "blink state moved while disabled")
   `SDD_ASSERT_NXT(a_redraw_latch, clock, reset, accept && redraw, shown_valid_ff && shown_value_ff == $past(value), "shown value not taken on redraw")
   `SDD_ASSERT_IMP(a_value_cap, clock, reset, 1'b1, shown_value_ff <= sdd_pkg::VALUE_W'(sdd_pkg::SCORE_CAP), "shown value above cap")

endmodule

>>> sv/score_digit_display_blink.sv
// Score digit display with blink: top level.
// Usage: each item on req_ (score, blink_enable) is one display frame and
// yields exactly one item on rsp_ with eight digit codes (10 = blank), a
// redrawn flag and a visible flag. Items leave in the order they arrive.
// The csr_ write channel sets blank_leading_zeros; csr_ready is always high.
// Write it only while no item is in flight.
// Path: an accepted item is loaded into the first of 27 shift-and-add-3
// cells, crosses the rest of the chain and is then loaded into the output
// register. Throughput: one item per cycle while the output is not held
// by rsp_stall; the chain of conversion cells sets the latency, each cell
// doing one bit step.
// Stall: when rsp_stall holds the output register, the items behind it
// close up into empty cells; req_stall rises only when every cell and the
// output register are full.
// Reset (synchronous, active high): empties the chain, clears the digit
// store, blink counter, hidden flag and blanking; the first frame redraws.
// Depends on sdd_pkg, sdd_entry, sdd_dabble_cell and the assertion header.
`include "score_digit_display_blink_assert.svh"

module score_digit_display_blink (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdd_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int N = sdd_pkg::CELL_COUNT;

   logic                blank_ff;
   logic [N:0]          free;
   logic [N:0]          chain_valid;
   sdd_pkg::cell_type   chain_data [N+1];
   logic [N-1:0]        cell_valid;
   logic                accept;

   logic                rsp_valid_ff;
   sdd_pkg::rsp_type    rsp_payload_ff;
   sdd_pkg::rsp_type    rsp_payload_in;
   sdd_pkg::digits_type store_ff;
   sdd_pkg::digits_type fresh;
   sdd_pkg::digits_type shown;
   sdd_pkg::cell_type   last;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         blank_ff <= csr_data;
      end
   end

   // A slot is free if the output can move or any slot from here on is empty
   assign cell_valid = chain_valid[N:1];

   always_comb begin
      free[N] = !rsp_valid_ff || !rsp_stall;
      for (int k = 0; k < N; k++) begin
         free[k] = free[N] ||
                   ((cell_valid | ((N'(1) << k) - N'(1))) != {N{1'b1}});
      end
   end

   assign req_stall = !free[0];
   assign accept    = req_valid && free[0];

   sdd_entry u_entry (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_payload),
      .blank      (blank_ff),
      .first_data (chain_data[0])
   );

   assign chain_valid[0] = req_valid;

   // Conversion chain: one cell per binary bit
   for (genvar g = 0; g < N; g++) begin : g_cell
      sdd_dabble_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (free[g]),
         .prev_valid (chain_valid[g]),
         .prev_data  (chain_data[g]),
         .cur_valid  (chain_valid[g+1]),
         .cur_data   (chain_data[g+1])
      );
   end

   // Format the finished item: fresh digits on redraw, held digits otherwise
   assign last = chain_data[N];

   always_comb begin
      fresh = sdd_pkg::blank_digits(last.bcd, last.blank);
      shown = last.redraw ? fresh : store_ff;
      rsp_payload_in.digit_0 = shown[0];
      rsp_payload_in.digit_1 = shown[1];
      rsp_payload_in.digit_2 = shown[2];
      rsp_payload_in.digit_3 = shown[3];
      rsp_payload_in.digit_4 = shown[4];
      rsp_payload_in.digit_5 = shown[5];
      rsp_payload_in.digit_6 = shown[6];
      rsp_payload_in.digit_7 = shown[7];
      rsp_payload_in.redrawn = last.redraw;
      rsp_payload_in.visible = last.visible;
   end

   // Output register and digit store
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         store_ff     <= '0;
      end else if (free[N]) begin
         rsp_valid_ff <= chain_valid[N];
         if (chain_valid[N] && last.redraw) begin
            store_ff <= fresh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free[N] && chain_valid[N]) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `SDD_ASSERT_NXT(a_enter_chain, clock, reset, accept, chain_valid[1], "accepted item missing from first cell")
   `SDD_ASSERT_IMP(a_units_shown, clock, reset, rsp_valid_ff, rsp_payload_ff.digit_7 != sdd_pkg::BLANK_CODE, "units digit blanked")
   `SDD_ASSERT_IMP(a_store_match, clock, reset, rsp_valid_ff, rsp_payload_ff.digit_0 == store_ff[0] && rsp_payload_ff.digit_7 == store_ff[7], "output digits differ from store")

endmodule

>>> dv/score_digit_display_blink_tb.sv
// Self-checking testbench for the score digit display blink block.
// Depends on sdd_pkg for the item types and the display constants.
`timescale 1ns / 1ps

module score_digit_display_blink_tb;

   // Flow patterns of the result side
   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_HOLD} stall_mode_type;

   // One row of the directed part; result is used only when typed is set
   typedef struct packed {
      bit               write_cfg;
      bit               cfg_value;
      logic [31:0]      score;
      bit               blink;
      bit               typed;
      sdd_pkg::rsp_type result;
   } step_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 140;
   localparam longint unsigned DISPLAY_MAX = sdd_pkg::SCORE_CAP;

   // Expected results read straight off the digit pattern: hex digit A is a blank
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 1'b0, 32'd0,          1'b0, 1'b1, {32'h00000000, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'd0,          1'b0, 1'b1, {32'h00000000, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b1, {32'h00000000, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'h8000_0000,  1'b0, 1'b1, {32'h00000000, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'd99999999,   1'b0, 1'b1, {32'h99999999, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'h7FFF_FFFF,  1'b0, 1'b1, {32'h99999999, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'd100000000,  1'b0, 1'b1, {32'h99999999, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'd12345678,   1'b1, 1'b1, {32'h12345678, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'd7,          1'b1, 1'b0, 34'd0},
      '{1'b0, 1'b0, 32'd1000,       1'b1, 1'b0, 34'd0},
      '{1'b0, 1'b0, 32'd1000,       1'b0, 1'b0, 34'd0},
      '{1'b1, 1'b1, 32'd1000,       1'b0, 1'b1, {32'h00001000, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'd5,          1'b0, 1'b1, {32'hAAAAAAA5, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'd0,          1'b0, 1'b1, {32'hAAAAAAA0, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'h8000_0000,  1'b0, 1'b1, {32'hAAAAAAA0, 1'b0, 1'b1}},
      '{1'b0, 1'b0, 32'd10000000,   1'b0, 1'b1, {32'h10000000, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'd10,         1'b0, 1'b1, {32'hAAAAAA10, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'h7FFF_FFFF,  1'b0, 1'b1, {32'h99999999, 1'b1, 1'b1}},
      '{1'b0, 1'b0, 32'd90909,      1'b1, 1'b0, 34'd0},
      '{1'b0, 1'b0, 32'd1,          1'b0, 1'b0, 34'd0},
      '{1'b1, 1'b0, 32'd1,          1'b0, 1'b0, 34'd0},
      '{1'b0, 1'b0, 32'd100,        1'b0, 1'b0, 34'd0},
      '{1'b0, 1'b0, 32'd99999998,   1'b1, 1'b0, 34'd0}
   };

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   sdd_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   sdd_pkg::rsp_type rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic             csr_data    = 1'b0;

   // Display state as the block should hold it
   logic [26:0] shown_score;
   bit          shown_once;
   logic [3:0]  digits_held [sdd_pkg::OUT_DIGITS];
   int unsigned blink_frames;
   bit          display_hidden;
   bit          blank_zeros;

   sdd_pkg::rsp_type frames_pending [$];
   sdd_pkg::rsp_type frame_due;
   logic [31:0]      last_score;
   int               mismatches;
   int               frames_sent;
   int               frames_checked;
   int               redraws_seen;
   int               blink_toggles;
   int               blank_writes;

   score_digit_display_blink uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("score_digit_display_blink_tb: FAIL");
      $finish;
   end

   // Advance the display state by one frame and return what it should show
   function automatic sdd_pkg::rsp_type display_frame(input sdd_pkg::req_type item);
      int unsigned      raw;
      int unsigned      value;
      int unsigned      rest;
      int unsigned      weight;
      logic [3:0]       d;
      bit               lead;
      bit               redraw;
      sdd_pkg::rsp_type r;
      raw = item.score;
      if (raw[31]) begin
         value = 0;
      end else if (raw > DISPLAY_MAX) begin
         value = int'(DISPLAY_MAX);
      end else begin
         value = raw;
      end
      // Count blink frames; wrap and toggle the hidden flag
      if (item.blink_enable) begin
         if (blink_frames + 1 >= sdd_pkg::BLINK_FRAMES) begin
            blink_frames   = 0;
            display_hidden = !display_hidden;
            blink_toggles++;
         end else begin
            blink_frames++;
         end
      end
      redraw = !shown_once || value != shown_score;
      if (redraw) begin
         rest   = value;
         weight = 10000000;
         lead   = 1'b0;
         for (int j = 0; j < sdd_pkg::OUT_DIGITS; j++) begin
            d      = 4'(rest / weight);
            rest   = rest % weight;
            weight = weight / 10;
            if (!blank_zeros || lead || d != 4'd0 || j == sdd_pkg::OUT_DIGITS - 1) begin
               lead           = 1'b1;
               digits_held[j] = d;
            end else begin
               digits_held[j] = sdd_pkg::BLANK_CODE;
            end
         end
         shown_score = 27'(value);
         shown_once  = 1'b1;
      end
      r.digit_0 = digits_held[0];
      r.digit_1 = digits_held[1];
      r.digit_2 = digits_held[2];
      r.digit_3 = digits_held[3];
      r.digit_4 = digits_held[4];
      r.digit_5 = digits_held[5];
      r.digit_6 = digits_held[6];
      r.digit_7 = digits_held[7];
      r.redrawn = redraw;
      r.visible = !display_hidden;
      return r;
   endfunction

   function automatic int unsigned ten_to(input int k);
      int unsigned p;
      p = 1;
      for (int i = 0; i < k; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   // Mostly in-range values of random length, with repeats, negatives and overflow
   function automatic logic [31:0] pick_score();
      int unsigned roll;
      int          k;
      logic [31:0] s;
      roll = $urandom_range(0, 99);
      k    = $urandom_range(1, 8);
      if (roll < 25) begin
         s = last_score;
      end else if (roll < 35) begin
         s = {1'b1, 31'($urandom)};
      end else if (roll < 43) begin
         s = $urandom_range(32'h7FFF_FFFF, 32'd100000000);
      end else if (roll < 53) begin
         case ($urandom_range(0, 7))
            0:       s = 32'd0;
            1:       s = 32'hFFFF_FFFF;
            2:       s = 32'h8000_0000;
            3:       s = 32'h7FFF_FFFF;
            4:       s = 32'd100000000;
            5:       s = ten_to(k);
            6:       s = ten_to(k) - 1;
            default: s = 32'd99999999;
         endcase
      end else if (roll < 60) begin
         s = $urandom;
      end else begin
         s = $urandom_range(0, ten_to(k) - 1);
      end
      last_score = s;
      return s;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Present one frame, hold it until accepted, then queue its expected result
   task automatic send_frame(input sdd_pkg::req_type item, input bit typed,
                             input sdd_pkg::rsp_type given);
      sdd_pkg::rsp_type predicted;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = display_frame(item);
      frames_pending.push_back(typed ? given : predicted);
      frames_sent++;
   endtask

   // Stop sending and wait until every queued frame has come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_pending.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_blanking(input bit setting);
      settle_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= setting;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      blank_zeros = setting;
      blank_writes++;
      csr_valid <= 1'b0;
   endtask

   // Random frames in bursts with random gaps; optionally drain halfway
   task automatic run_phase(input int count, input bit pause_midway);
      sdd_pkg::req_type item;
      int               burst;
      int               gap;
      burst = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) begin
            settle_pipeline();
         end
         item.score        = pick_score();
         item.blink_enable = ($urandom_range(0, 3) != 0);
         send_frame(item, 1'b0, '0);
         burst--;
         if (burst == 0) begin
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 16);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Result side: stall in stretches of changing density
   initial begin
      stall_mode_type mode;
      int             span;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = (mode == FLOW_HOLD) ? $urandom_range(10, 40) : $urandom_range(10, 80);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            case (mode)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default:    rsp_stall <= (c < span - 3);
            endcase
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_pending.size() == 0) begin
            $error("result item arrived with no frame pending");
            mismatches++;
         end else begin
            frame_due = frames_pending.pop_front();
            check_field("digit_0", frame_due.digit_0, rsp_payload.digit_0);
            check_field("digit_1", frame_due.digit_1, rsp_payload.digit_1);
            check_field("digit_2", frame_due.digit_2, rsp_payload.digit_2);
            check_field("digit_3", frame_due.digit_3, rsp_payload.digit_3);
            check_field("digit_4", frame_due.digit_4, rsp_payload.digit_4);
            check_field("digit_5", frame_due.digit_5, rsp_payload.digit_5);
            check_field("digit_6", frame_due.digit_6, rsp_payload.digit_6);
            check_field("digit_7", frame_due.digit_7, rsp_payload.digit_7);
            check_field("redrawn", frame_due.redrawn, rsp_payload.redrawn);
            check_field("visible", frame_due.visible, rsp_payload.visible);
            frames_checked++;
            if (frame_due.redrawn) begin
               redraws_seen++;
            end
         end
      end
   end

   initial begin
      sdd_pkg::req_type item;
      shown_score    = '0;
      shown_once     = 1'b0;
      blink_frames   = 0;
      display_hidden = 1'b0;
      blank_zeros    = 1'b0;
      last_score     = '0;
      for (int j = 0; j < sdd_pkg::OUT_DIGITS; j++) begin
         digits_held[j] = 4'd0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: extremes, clamping, blanking and the held digits
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].write_cfg) begin
            write_blanking(DIRECTED[r].cfg_value);
         end
         item.score        = DIRECTED[r].score;
         item.blink_enable = DIRECTED[r].blink;
         send_frame(item, DIRECTED[r].typed, DIRECTED[r].result);
      end

      // Random frames under alternating and then random blanking
      for (int p = 0; p < PHASES; p++) begin
         write_blanking(p < 4 ? (p % 2 == 0) : bit'($urandom_range(0, 1)));
         run_phase(PHASE_ITEMS, p == 2);
      end

      // Drain, then watch a little longer for stray results
      settle_pipeline();
      repeat (40) @(posedge clock);
      if (frames_pending.size() != 0) begin
         $error("%0d expected results never arrived", frames_pending.size());
         mismatches++;
      end
      $display("Checked %0d of %0d frames: %0d redraws, %0d blink toggles,",
               frames_checked, frames_sent, redraws_seen, blink_toggles);
      $display("blanking register written %0d times, %0d mismatches.",
               blank_writes, mismatches);
      if (mismatches == 0) begin
         $display("score_digit_display_blink_tb: PASS");
      end else begin
         $display("score_digit_display_blink_tb: FAIL");
      end
      $finish;
   end

endmodule
